/* hdl/plcs_pkg.sv */
// Shared types and constants of the periodic link command sequencer.
`timescale 1ns / 1ps
`default_nettype none

package plcs_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUND_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ATTEMPTS = 2'd1;

   localparam logic [7:0] ROUND_PERIOD_RESET = 8'd20;
   localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd3;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // input item kinds and line classes
   localparam logic       CMD_TICK  = 1'b0;
   localparam logic [1:0] KIND_ACK  = 2'd0;
   localparam logic [1:0] KIND_NACK = 2'd1;

   // outstanding command of a round
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_PING       = 3'd1;
   localparam logic [2:0] PH_CONNECT    = 3'd2;
   localparam logic [2:0] PH_CONFIG     = 3'd3;
   localparam logic [2:0] PH_STOCK      = 3'd4;
   localparam logic [2:0] PH_SEND       = 3'd5;
   localparam logic [2:0] PH_DISCONNECT = 3'd6;

   // result codes
   localparam logic [2:0] CODE_PING    = 3'd0;
   localparam logic [2:0] CODE_CONNECT = 3'd1;
   localparam logic [2:0] CODE_STOCK   = 3'd3;
   localparam logic [2:0] CODE_FINISH  = 3'd6;

   // classified item passed from front to back
   typedef struct packed {
      logic               is_tick;
      logic               is_ack;
      logic               is_nack;
      logic signed [15:0] qty;
   } item_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

endpackage

`default_nettype wire

/* hdl/plcs_front.sv */
// Front stage: takes input beats and classifies them into items.
`timescale 1ns / 1ps
`default_nettype none

module plcs_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic [1:0]         req_response_kind,
   input  wire logic signed [15:0] req_stock_quantity,
   input  wire logic               q_full,
   output logic                    q_push,
   output plcs_pkg::item_type      q_item
);

   logic               front_valid_ff;
   logic               front_valid_in;
   plcs_pkg::item_type front_item_ff;
   plcs_pkg::item_type front_item_in;
   logic               load;

   assign req_stall = front_valid_ff && q_full;
   assign load      = req_valid && !req_stall;
   assign q_push    = front_valid_ff && !q_full;
   assign q_item    = front_item_ff;

   always_comb begin
      front_valid_in = load || (front_valid_ff && !q_push);
      front_item_in  = front_item_ff;
      if (load) begin
         front_item_in.is_tick = (req_command == plcs_pkg::CMD_TICK);
         front_item_in.is_ack  = (req_command != plcs_pkg::CMD_TICK) &&
                                 (req_response_kind == plcs_pkg::KIND_ACK);
         front_item_in.is_nack = (req_command != plcs_pkg::CMD_TICK) &&
                                 (req_response_kind == plcs_pkg::KIND_NACK);
         front_item_in.qty     = req_stock_quantity;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_item_ff <= front_item_in;
   end

endmodule

`default_nettype wire

/* hdl/plcs_queue.sv */
// Short item queue between the front and back stages.
`timescale 1ns / 1ps
`default_nettype none

module plcs_queue #(
   parameter int DEPTH = plcs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire plcs_pkg::item_type  push_item,
   input  wire logic                pop,
   output plcs_pkg::item_type       head_item,
   output logic                     full,
   output logic                     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST   = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

   plcs_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_MAX);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* hdl/plcs_back.sv */
// Back stage: round sequencing, settings registers and the result register.
`timescale 1ns / 1ps
`default_nettype none

module plcs_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire plcs_pkg::csr_write_type csr_wr,
   output logic                    csr_ready,
   input  wire logic               q_empty,
   input  wire plcs_pkg::item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_command_code,
   output logic signed [15:0]      rsp_stock_value,
   output logic                    rsp_station_mode,
   output logic                    rsp_round_failed
);

   logic [7:0] period_ff, period_in;
   logic [3:0] max_att_ff, max_att_in;

   logic [7:0] sec_ff, sec_in;
   logic       station_ff, station_in;
   logic [2:0] phase_ff, phase_in;
   logic [3:0] attempt_ff, attempt_in;
   logic       error_ff, error_in;

   // remainder pass bringing the second count below a new period
   logic       busy_ff, busy_in;
   logic [2:0] step_ff, step_in;
   logic [7:0] rem_ff, rem_in;
   logic [8:0] rem_trial;

   logic              out_valid_ff, out_valid_in;
   logic [2:0]        out_code_ff, out_code_in;
   logic signed [15:0] out_stock_ff, out_stock_in;
   logic              out_station_ff, out_station_in;
   logic              out_failed_ff, out_failed_in;

   logic       take;
   logic       cfg_we;
   logic [8:0] sec_inc;
   logic [3:0] limit;
   logic [3:0] att_next;
   logic       resolved;
   logic       emit;

   assign csr_ready = !busy_ff;
   assign cfg_we    = csr_wr.valid && csr_ready;
   assign take      = !q_empty && !busy_ff && (!out_valid_ff || !rsp_stall);
   assign q_pop     = take;

   assign rsp_valid        = out_valid_ff;
   assign rsp_command_code = out_code_ff;
   assign rsp_stock_value  = out_stock_ff;
   assign rsp_station_mode = out_station_ff;
   assign rsp_round_failed = out_failed_ff;

   assign sec_inc   = {1'b0, sec_ff} + 9'd1;
   assign limit     = (max_att_ff == 4'd0) ? 4'd1 : max_att_ff;
   assign att_next  = attempt_ff + 4'd1;
   assign rem_trial = {rem_ff, sec_ff[step_ff]};

   always_comb begin
      period_in  = period_ff;
      max_att_in = max_att_ff;
      sec_in     = sec_ff;
      station_in = station_ff;
      phase_in   = phase_ff;
      attempt_in = attempt_ff;
      error_in   = error_ff;
      busy_in    = busy_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      resolved   = 1'b0;
      emit       = 1'b0;

      out_code_in    = out_code_ff;
      out_stock_in   = out_stock_ff;
      out_station_in = out_station_ff;
      out_failed_in  = out_failed_ff;

      if (cfg_we) begin
         case (csr_wr.index)
            plcs_pkg::CSR_ROUND_PERIOD: begin
               period_in = csr_wr.data;
               if (csr_wr.data != 8'd0) begin
                  busy_in = 1'b1;
                  step_in = 3'd7;
                  rem_in  = 8'd0;
               end
            end
            plcs_pkg::CSR_MAX_ATTEMPTS: max_att_in = csr_wr.data[3:0];
            default: ;
         endcase
      end

      if (busy_ff) begin
         if (rem_trial >= {1'b0, period_ff}) begin
            rem_in = 8'(rem_trial - {1'b0, period_ff});
         end else begin
            rem_in = rem_trial[7:0];
         end
         step_in = step_ff - 3'd1;
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            sec_in  = rem_in;
         end
      end

      if (take) begin
         if (q_item.is_tick) begin
            if (period_ff == 8'd0) begin
               sec_in = sec_inc[7:0];
            end else begin
               sec_in = (sec_inc == {1'b0, period_ff}) ? 8'd0 : sec_inc[7:0];
            end
            if (sec_in == 8'd0 && phase_ff == plcs_pkg::PH_IDLE) begin
               attempt_in   = 4'd0;
               error_in     = 1'b0;
               emit         = 1'b1;
               out_stock_in = 16'sd0;
               out_failed_in = 1'b0;
               if (station_ff) begin
                  phase_in    = plcs_pkg::PH_CONNECT;
                  out_code_in = plcs_pkg::CODE_CONNECT;
               end else begin
                  phase_in    = plcs_pkg::PH_PING;
                  out_code_in = plcs_pkg::CODE_PING;
               end
            end
         end else if (phase_ff != plcs_pkg::PH_IDLE) begin
            attempt_in = att_next;
            resolved   = q_item.is_ack || q_item.is_nack || (att_next >= limit);
            if (resolved) begin
               attempt_in    = 4'd0;
               error_in      = error_ff || !q_item.is_ack;
               emit          = 1'b1;
               out_stock_in  = 16'sd0;
               out_failed_in = 1'b0;
               case (phase_ff)
                  plcs_pkg::PH_PING: begin
                     if (q_item.is_ack) begin
                        station_in = 1'b1;
                     end
                     phase_in      = plcs_pkg::PH_IDLE;
                     out_code_in   = plcs_pkg::CODE_FINISH;
                     out_failed_in = error_in;
                  end
                  plcs_pkg::PH_DISCONNECT: begin
                     if (error_in) begin
                        station_in = 1'b0;
                     end
                     phase_in      = plcs_pkg::PH_IDLE;
                     out_code_in   = plcs_pkg::CODE_FINISH;
                     out_failed_in = error_in;
                  end
                  default: begin
                     // connect..send: the next command goes out
                     phase_in    = phase_ff + 3'd1;
                     out_code_in = phase_ff;
                     if (phase_ff == plcs_pkg::CODE_STOCK) begin
                        out_stock_in = q_item.qty;
                     end
                  end
               endcase
            end
         end
         out_station_in = station_in;
      end

      if (take) begin
         out_valid_in = emit;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= plcs_pkg::ROUND_PERIOD_RESET;
         max_att_ff   <= plcs_pkg::MAX_ATTEMPTS_RESET;
         sec_ff       <= 8'd0;
         station_ff   <= 1'b0;
         phase_ff     <= plcs_pkg::PH_IDLE;
         attempt_ff   <= 4'd0;
         error_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         max_att_ff   <= max_att_in;
         sec_ff       <= sec_in;
         station_ff   <= station_in;
         phase_ff     <= phase_in;
         attempt_ff   <= attempt_in;
         error_ff     <= error_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      step_ff        <= step_in;
      rem_ff         <= rem_in;
      out_code_ff    <= out_code_in;
      out_stock_ff   <= out_stock_in;
      out_station_ff <= out_station_in;
      out_failed_ff  <= out_failed_in;
   end

endmodule

`default_nettype wire

/* hdl/periodic_link_command_sequencer.sv */
// Usage: req_ beats are one-second ticks (req_command 0) or classified response
// lines (req_command 1, req_response_kind ACK/NACK/other, req_stock_quantity).
// Each beat gives at most one rsp_ beat: the next command code, or the
// round-finished report with rsp_round_failed; rsp_station_mode follows.
// A beat moves on valid high with stall low on either channel.
// csr_ writes (valid/ready) set round_period (index 0) and max_attempts
// (index 1); write them only while the block is idle.
// Taken beats pass the front register and queue; the result is registered.
// Throughput: one request beat per cycle while req_stall is low; the back stage
// updates the sequencer state as it takes each item.
// Writing a non-zero round_period starts a bit-serial remainder pass on the
// second counter; csr_ready is low and no item is processed meanwhile.
// A stalled result holds in the output register; the queue and front register
// keep absorbing beats until full, then req_stall rises.
// Reset (synchronous) returns to probe mode, idle, period 20, attempts 3;
// csr_ready is high straight after reset.
`timescale 1ns / 1ps
`default_nettype none

module periodic_link_command_sequencer #(
   parameter int QUEUE_DEPTH = plcs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_command,
   input  wire logic [1:0]                          req_response_kind,
   input  wire logic signed [15:0]                  req_stock_quantity,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [2:0]                               rsp_command_code,
   output logic signed [15:0]                       rsp_stock_value,
   output logic                                     rsp_station_mode,
   output logic                                     rsp_round_failed,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [plcs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [plcs_pkg::CSR_DATA_W-1:0]     csr_data
);

   plcs_pkg::item_type      push_item;
   plcs_pkg::item_type      head_item;
   plcs_pkg::csr_write_type csr_wr;
   logic                    q_push, q_pop, q_full, q_empty;

   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   plcs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_response_kind  (req_response_kind),
      .req_stock_quantity (req_stock_quantity),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_item             (push_item)
   );

   plcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   plcs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr           (csr_wr),
      .csr_ready        (csr_ready),
      .q_empty          (q_empty),
      .q_item           (head_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_code (rsp_command_code),
      .rsp_stock_value  (rsp_stock_value),
      .rsp_station_mode (rsp_station_mode),
      .rsp_round_failed (rsp_round_failed)
   );

endmodule

`default_nettype wire

/* bench/plcs_link_checker.sv */
// Checker for the link command sequencer: predicts each result beat and compares it.
`timescale 1ns / 1ps

module plcs_link_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic                             req_command,
   input  wire logic [1:0]                       req_response_kind,
   input  wire logic signed [15:0]               req_stock_quantity,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic [2:0]                       rsp_command_code,
   input  wire logic signed [15:0]               rsp_stock_value,
   input  wire logic                             rsp_station_mode,
   input  wire logic                             rsp_round_failed,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [plcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [plcs_pkg::CSR_DATA_W-1:0]  csr_data,
   output int unsigned                           fail_count,
   output int unsigned                           outstanding
);

   typedef struct packed {
      logic [2:0]         code;
      logic signed [15:0] stock;
      logic               station;
      logic               failed;
   } link_result_type;

   link_result_type    expected_q[$];
   int unsigned        fails = 0;
   int unsigned        waiting = 0;

   logic [7:0]         round_period;
   logic [3:0]         max_attempts;
   logic [7:0]         second_count;
   logic               station_flag;
   logic [2:0]         link_phase;
   logic [3:0]         attempt_count;
   logic               error_seen;
   logic signed [15:0] held_qty;

   assign fail_count  = fails;
   assign outstanding = waiting;

   task automatic queue_result(input logic [2:0] code, input logic signed [15:0] stock,
                               input logic failed);
      link_result_type r;
      r.code    = code;
      r.stock   = stock;
      r.station = station_flag;
      r.failed  = failed;
      expected_q.push_back(r);
   endtask

   task automatic advance_link(input logic cmd, input logic [1:0] kind,
                               input logic signed [15:0] qty);
      logic [8:0] next_count;
      logic [3:0] limit;
      logic       acked;
      logic       resolved;
      logic [2:0] issued;
      if (cmd == plcs_pkg::CMD_TICK) begin
         next_count = {1'b0, second_count} + 9'd1;
         // a zero period simply lets the counter wrap at 256
         if (round_period != 8'd0)
            next_count = next_count % round_period;
         second_count = next_count[7:0];
         if (second_count == 8'd0 && link_phase == plcs_pkg::PH_IDLE) begin
            attempt_count = 4'd0;
            error_seen    = 1'b0;
            if (station_flag) begin
               link_phase = plcs_pkg::PH_CONNECT;
               queue_result(plcs_pkg::CODE_CONNECT, 16'sd0, 1'b0);
            end else begin
               link_phase = plcs_pkg::PH_PING;
               queue_result(plcs_pkg::CODE_PING, 16'sd0, 1'b0);
            end
         end
      end else if (link_phase != plcs_pkg::PH_IDLE) begin
         limit         = (max_attempts == 4'd0) ? 4'd1 : max_attempts;
         attempt_count = attempt_count + 4'd1;
         acked         = (kind == plcs_pkg::KIND_ACK);
         resolved      = acked || kind == plcs_pkg::KIND_NACK || attempt_count >= limit;
         if (resolved) begin
            attempt_count = 4'd0;
            if (!acked)
               error_seen = 1'b1;
            if (link_phase == plcs_pkg::PH_PING || link_phase == plcs_pkg::PH_DISCONNECT) begin
               if (link_phase == plcs_pkg::PH_PING && acked)
                  station_flag = 1'b1;
               if (link_phase == plcs_pkg::PH_DISCONNECT && error_seen)
                  station_flag = 1'b0;
               link_phase = plcs_pkg::PH_IDLE;
               queue_result(plcs_pkg::CODE_FINISH, 16'sd0, error_seen);
            end else begin
               // the next command's code equals the phase just resolved
               issued     = link_phase;
               link_phase = link_phase + 3'd1;
               if (issued == plcs_pkg::CODE_STOCK) begin
                  held_qty = qty;
                  queue_result(plcs_pkg::CODE_STOCK, held_qty, 1'b0);
               end else begin
                  queue_result(issued, 16'sd0, 1'b0);
               end
            end
         end
      end
   endtask

   task automatic report(input string field, input integer want_v, input integer got_v);
      fails++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want_v, got_v);
   endtask

   always @(posedge clock) begin
      link_result_type want;
      if (reset) begin
         round_period  = plcs_pkg::ROUND_PERIOD_RESET;
         max_attempts  = plcs_pkg::MAX_ATTEMPTS_RESET;
         second_count  = 8'd0;
         station_flag  = 1'b0;
         link_phase    = plcs_pkg::PH_IDLE;
         attempt_count = 4'd0;
         error_seen    = 1'b0;
         held_qty      = 16'sd0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               plcs_pkg::CSR_ROUND_PERIOD: round_period = csr_data;
               plcs_pkg::CSR_MAX_ATTEMPTS: max_attempts = csr_data[3:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               fails++;
               $display("%0t: unexpected result beat, code %0d", $time, rsp_command_code);
            end else begin
               want = expected_q.pop_front();
               if (rsp_command_code !== want.code)
                  report("command_code", want.code, rsp_command_code);
               if (rsp_stock_value !== want.stock)
                  report("stock_value", want.stock, rsp_stock_value);
               if (rsp_station_mode !== want.station)
                  report("station_mode", want.station, rsp_station_mode);
               if (rsp_round_failed !== want.failed)
                  report("round_failed", want.failed, rsp_round_failed);
            end
         end
         if (req_valid && !req_stall)
            advance_link(req_command, req_response_kind, req_stock_quantity);
      end
      waiting = expected_q.size();
   end

endmodule

/* bench/tb_periodic_link_command_sequencer.sv */
// Testbench top for the link command sequencer: stimulus, handshake timing and verdict.
`timescale 1ns / 1ps

module tb_periodic_link_command_sequencer;

   localparam logic       CMD_LINE    = ~plcs_pkg::CMD_TICK;
   localparam logic [1:0] KIND_OTHER  = 2'd2;
   localparam logic [1:0] KIND_SPARE  = 2'd3;   // unused class, read as other
   localparam int         ITEM_TARGET = 1750;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_command        = 1'b0;
   logic [1:0]             req_response_kind  = 2'd0;
   logic signed [15:0]     req_stock_quantity = 16'sd0;
   logic                   rsp_stall          = 1'b0;
   logic                   csr_valid          = 1'b0;
   logic [plcs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [plcs_pkg::CSR_DATA_W-1:0]  csr_data  = '0;

   wire logic              req_stall;
   wire logic              rsp_valid;
   wire logic [2:0]        rsp_command_code;
   wire logic signed [15:0] rsp_stock_value;
   wire logic              rsp_station_mode;
   wire logic              rsp_round_failed;
   wire logic              csr_ready;
   int unsigned            fail_count;
   int unsigned            outstanding;

   bit          quiet     = 1'b0;
   bit          hold_req  = 1'b0;
   int          rush_left = 0;
   int          items_sent = 0;
   logic [7:0]  run_period = plcs_pkg::ROUND_PERIOD_RESET;
   int          attempt_limit = 3;

   periodic_link_command_sequencer dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_command, .req_response_kind, .req_stock_quantity,
      .rsp_valid, .rsp_stall, .rsp_command_code, .rsp_stock_value,
      .rsp_station_mode, .rsp_round_failed,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   plcs_link_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_command, .req_response_kind, .req_stock_quantity,
      .rsp_valid, .rsp_stall, .rsp_command_code, .rsp_stock_value,
      .rsp_station_mode, .rsp_round_failed,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .outstanding
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic signed [15:0] random_qty();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] random_other();
      return $urandom_range(0, 1) ? KIND_OTHER : KIND_SPARE;
   endfunction

   // one request beat, then maybe an idle gap on the sender side
   task automatic offer_beat(input logic cmd, input logic [1:0] kind,
                             input logic signed [15:0] qty);
      int r;
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_response_kind  <= kind;
      req_stock_quantity <= qty;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (rush_left > 0) begin
         rush_left--;
      end else if (!quiet) begin
         r = $urandom_range(0, 99);
         if (r >= 60) begin
            req_valid <= 1'b0;
            repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clock);
         end
      end
   endtask

   task automatic send_tick();
      offer_beat(plcs_pkg::CMD_TICK, 2'($urandom_range(0, 3)), random_qty());
   endtask

   task automatic send_line(input logic [1:0] kind);
      offer_beat(CMD_LINE, kind, random_qty());
   endtask

   // drain everything in flight before touching the registers
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_link(input logic [7:0] period, input logic [3:0] attempts);
      csr_valid <= 1'b1;
      csr_index <= plcs_pkg::CSR_ROUND_PERIOD;
      csr_data  <= period;
      do @(posedge clock); while (!csr_ready);
      csr_index <= plcs_pkg::CSR_MAX_ATTEMPTS;
      csr_data  <= {4'd0, attempts};
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      run_period    = period;
      attempt_limit = (attempts == 4'd0) ? 1 : attempts;
   endtask

   // resolve one outstanding command: mostly ACK, sometimes NACK or a run of misses
   task automatic answer_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 72) begin
         send_line(plcs_pkg::KIND_ACK);
      end else if (r < 82) begin
         send_line(plcs_pkg::KIND_NACK);
      end else if (r < 92) begin
         repeat ($urandom_range(0, attempt_limit - 1)) send_line(random_other());
         send_line(plcs_pkg::KIND_ACK);
      end else begin
         repeat (attempt_limit) send_line(random_other());
      end
   endtask

   // one period of ticks guarantees exactly one wrap, then answers for a full round
   task automatic run_round();
      int n;
      int r;
      n = (run_period == 8'd0) ? 256 : run_period;
      repeat (n) send_tick();
      for (int cmd_no = 0; cmd_no < 5; cmd_no++) begin
         r = $urandom_range(0, 99);
         if (r < 8)
            send_tick();
         else if (r < 14)
            repeat ($urandom_range(1, 4))
               offer_beat(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), random_qty());
         answer_command();
      end
   endtask

   initial begin : receiver
      int r;
      int span;
      forever begin
         r = $urandom_range(0, 99);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            span = $urandom_range(80, 120);
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            span = 1;
         end else if (r < 50) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 6);
         end else if (r < 88) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 3);
         end else if (r < 97) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(4, 15);
         end else begin
            rsp_stall <= 1'b1;
            span = $urandom_range(20, 50);
         end
         repeat (span) @(posedge clock);
      end
   end

   initial begin : stimulus
      int phase_no;
      int phase_end;
      int r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      program_link(8'd1, 4'd3);
      send_line(plcs_pkg::KIND_ACK);     // line while idle is dropped
      send_tick();                       // ping
      send_line(KIND_OTHER);
      send_line(KIND_SPARE);
      send_line(KIND_OTHER);             // third miss fails the ping
      send_tick();
      send_line(plcs_pkg::KIND_ACK);     // into station mode
      send_tick();                       // connect
      send_tick();                       // wraps while busy: dropped
      send_line(plcs_pkg::KIND_NACK);
      offer_beat(CMD_LINE, plcs_pkg::KIND_ACK, 16'sh7FFF);
      repeat (3) send_line(plcs_pkg::KIND_ACK);    // send, disconnect, failed round
      send_tick();
      send_line(plcs_pkg::KIND_ACK);
      send_tick();
      send_line(plcs_pkg::KIND_ACK);
      offer_beat(CMD_LINE, plcs_pkg::KIND_ACK, 16'sh8000);
      repeat (3) send_line(plcs_pkg::KIND_ACK);
      settle();
      program_link(8'd1, 4'd0);          // zero attempts behaves as one
      send_tick();
      send_line(KIND_SPARE);

      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         settle();
         case (phase_no)
            0: program_link(8'd20, 4'd3);
            1: program_link(8'd255, 4'd15);
            2: program_link(8'd0, 4'd1);
            3: program_link(8'd1, 4'd15);
            default: begin
               r = $urandom_range(0, 99);
               program_link(r < 80 ? 8'($urandom_range(1, 4)) : 8'($urandom_range(5, 24)),
                            4'($urandom_range(0, 15)));
            end
         endcase
         quiet = ($urandom_range(0, 3) == 0);
         if (run_period != 8'd0 && run_period <= 8'd3 && phase_no % 3 == 0) begin
            hold_req  = 1'b1;
            rush_left = 80;
         end
         phase_end = items_sent + ((run_period == 8'd0 || run_period > 8'd100) ? 1 : 150);
         while (items_sent < phase_end)
            run_round();
         phase_no++;
      end

      settle();
      if (fail_count == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
hdl/plcs_pkg.sv
hdl/plcs_front.sv
hdl/plcs_queue.sv
hdl/plcs_back.sv
hdl/periodic_link_command_sequencer.sv
bench/plcs_link_checker.sv
bench/tb_periodic_link_command_sequencer.sv
